>>> rtl/core/rlee_pkg.sv
`timescale 1ns / 1ps

package rlee_pkg;

	// Input opcodes.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	// Widths of the payload fields.
	localparam int PIX_W  = 8;
	localparam int RUN_W  = 32;
	localparam int CFG_W  = 13;

	// Largest run length; runs saturate here.
	localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

	// Reset value of the image width register.
	localparam int WIDTH_RESET = 640;

	// Result queue between the run encoder and the output port.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef logic [PIX_W-1:0] pix_t;

	// One line buffer entry: the pixel two rows up and the pixel one row up.
	typedef struct packed {
		pix_t upper;
		pix_t middle;
	} line_t;

	// One result item.
	typedef struct packed {
		pix_t             code;
		logic [RUN_W-1:0] length;
		logic             last;
	} result_t;

endpackage

>>> rtl/core/rlee_ram.sv
`timescale 1ns / 1ps

module rlee_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port; a read of the address being
	// written in the same cycle returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/core/rle_edge_code_encoder.sv
// Edge-code run-length encoder for an 8-bit greyscale image in raster order.
// Pixel channel (pixel_valid, pixel_stall, opcode, pixel_value): one pixel per
// transfer, followed by image_width + 1 drain transfers that flush the image.
// Run channel (run_valid, run_stall, edge_code, run_length, last_run): one
// (code, length) run per transfer; the final run of the image has last_run set.
// Configuration channel (cfg_valid, cfg_ready, image_width): cfg_ready is always
// high; a write starts a new image; the user must make a write only while the
// block is idle, which the block does not enforce. Throughput is one pixel per
// cycle while pixel_stall is low. The line buffers sit in one RAM with one read
// and one write port, read at the transfer and written back from stage one; a
// width of one pixel is covered by forwarding the write-back data. A run is
// closed by the pixel transfer that carries the pixel image_width + 1 places
// after the run's end. Results wait in a four-entry queue; pixel_stall rises
// only when that queue holds three or more runs, so a stalled receiver stops the
// pixel side once three runs are waiting. Reset leaves the width at 640, empties
// the queue and marks the window empty; the line buffer RAM is not cleared.
`timescale 1ns / 1ps

module rle_edge_code_encoder #(
	parameter int MAX_WIDTH = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [rlee_pkg::CFG_W-1:0] image_width,
	input  logic                       pixel_valid,
	output logic                       pixel_stall,
	input  logic                       opcode,
	input  logic [7:0]                 pixel_value,
	output logic                       run_valid,
	input  logic                       run_stall,
	output logic [7:0]                 edge_code,
	output logic [31:0]                run_length,
	output logic                       last_run
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int DW = $clog2(MAX_WIDTH + 2);
	localparam int RESET_W = (rlee_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH :
		rlee_pkg::WIDTH_RESET;
	localparam int LINE_W = $bits(rlee_pkg::line_t);

	typedef struct packed {
		logic first;
		logic up_v;
		logic mid_v;
		logic low_v;
		logic has_centre;
		logic last;
		logic restart;
	} s1_ctl_t;

	typedef struct packed {
		logic has_centre;
		logic last;
		logic restart;
	} run_ctl_t;

	logic cfg_wr;
	logic adv;

	logic [WW-1:0] width_q;
	logic [WW-1:0] width_eff;
	logic [AW-1:0] col_q;
	logic [1:0]    row_q;
	logic [DW-1:0] drain_q;

	logic          drain;
	logic          restart;
	logic [AW-1:0] col0;
	logic [1:0]    row0;
	logic [DW-1:0] drain0;
	logic          skip;
	logic          take;
	logic          enter;
	logic [WW-1:0] col_inc;
	logic          col_wrap;
	s1_ctl_t       ctl0;

	logic                  v_s1;
	s1_ctl_t               ctl_s1;
	logic [AW-1:0]         col_s1;
	rlee_pkg::pix_t        pix_s1;
	logic                  fwd_s1;
	rlee_pkg::line_t       fwd_data_s1;
	logic [LINE_W-1:0]     rd_data;
	rlee_pkg::line_t       line_s1;
	rlee_pkg::line_t       wr_line;
	rlee_pkg::pix_t        low_data;
	logic                  ram_we;

	logic [2:0]            new_v;
	rlee_pkg::pix_t        new_d [3];
	logic [2:0]            win_v_q [3];
	rlee_pkg::pix_t        win_d_q [3][3];
	logic [2:0]            sh_v [3];
	rlee_pkg::pix_t        sh_d [3][3];

	logic                  v_s2;
	run_ctl_t              ctl_s2;
	logic [2:0]            snap_v_s2 [3];
	rlee_pkg::pix_t        snap_d_s2 [3][3];
	rlee_pkg::pix_t        diff [3][3];

	logic                  v_s3;
	run_ctl_t              ctl_s3;
	rlee_pkg::pix_t        diff_s3 [3][3];
	rlee_pkg::pix_t        code_max;

	logic                  v_s4;
	run_ctl_t              ctl_s4;
	rlee_pkg::pix_t        code_s4;

	rlee_pkg::pix_t             cur_code_q;
	logic [rlee_pkg::RUN_W-1:0] cur_len_q;
	rlee_pkg::pix_t             base_code;
	logic [rlee_pkg::RUN_W-1:0] base_len;
	rlee_pkg::pix_t             mid_code;
	logic [rlee_pkg::RUN_W-1:0] mid_len;
	logic                       push0;
	logic                       push1;
	rlee_pkg::result_t          res0;
	rlee_pkg::result_t          res1;

	rlee_pkg::result_t             fifo_q [rlee_pkg::FIFO_DEPTH];
	logic [rlee_pkg::FIFO_AW-1:0]  wr_ptr_q;
	logic [rlee_pkg::FIFO_AW-1:0]  rd_ptr_q;
	logic [rlee_pkg::FIFO_AW:0]    count_q;
	logic                          pop;
	rlee_pkg::result_t             head;

	// Configuration port: always ready; the width is clamped to 1..MAX_WIDTH.
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_comb begin
		if (image_width == '0) begin
			width_eff = WW'(1);
		end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = WW'(image_width);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WW'(RESET_W);
		end else if (cfg_wr) begin
			width_q <= width_eff;
		end
	end

	// The whole pipeline moves while the result queue has room for two runs.
	assign adv         = (count_q < (rlee_pkg::FIFO_AW + 1)'(rlee_pkg::FIFO_DEPTH - 1));
	assign pixel_stall = ~adv;
	assign take        = pixel_valid & ~pixel_stall;

	// Position of the incoming item in the image and the validity of its window column.
	always_comb begin
		drain    = (opcode == rlee_pkg::OP_DRAIN);
		restart  = ~drain && (drain_q != '0);
		col0     = restart ? '0 : col_q;
		row0     = restart ? 2'd0 : row_q;
		drain0   = restart ? '0 : drain_q;
		skip     = drain && (drain0 > DW'(width_q));
		enter    = take & ~skip;
		col_inc  = WW'(col0) + WW'(1);
		col_wrap = (col_inc >= width_q);

		ctl0.first      = (col0 == '0);
		ctl0.up_v       = (row0 == 2'd2);
		ctl0.mid_v      = (row0 != 2'd0) && (~drain || (drain0 < DW'(width_q)));
		ctl0.low_v      = ~drain;
		ctl0.has_centre = (row0 == 2'd2) || ((row0 == 2'd1) && (col0 != '0));
		ctl0.last       = drain && (drain0 == DW'(width_q));
		ctl0.restart    = restart;
	end

	// Column, row and drain counters advance with every item that is not ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= 2'd0;
			drain_q <= '0;
		end else if (cfg_wr) begin
			col_q   <= '0;
			row_q   <= 2'd0;
			drain_q <= '0;
		end else if (enter) begin
			drain_q <= drain0 + DW'(drain);
			if (col_wrap) begin
				col_q <= '0;
				row_q <= (row0 == 2'd2) ? 2'd2 : row0 + 2'd1;
			end else begin
				col_q <= AW'(col_inc);
				row_q <= row0;
			end
		end
	end

	// Line buffers: read at the transfer, written back from stage one.
	rlee_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_s1),
		.wdata (wr_line),
		.re    (enter),
		.raddr (col0),
		.rdata (rd_data)
	);

	// Stage one registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= enter;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1      <= ctl0;
			col_s1      <= col0;
			pix_s1      <= pixel_value;
			fwd_s1      <= v_s1 && (col_s1 == col0);
			fwd_data_s1 <= wr_line;
		end
	end

	// Stage one: merge the forwarded entry, write back and build the new column.
	always_comb begin
		line_s1        = fwd_s1 ? fwd_data_s1 : rlee_pkg::line_t'(rd_data);
		low_data       = ctl_s1.low_v ? pix_s1 : '0;
		wr_line.upper  = line_s1.middle;
		wr_line.middle = low_data;
		ram_we         = adv & v_s1;

		new_v    = {ctl_s1.low_v, ctl_s1.mid_v, ctl_s1.up_v};
		new_d[0] = line_s1.upper;
		new_d[1] = line_s1.middle;
		new_d[2] = low_data;

		for (int i = 0; i < 3; i++) begin
			sh_v[i][0] = win_v_q[i][1];
			sh_v[i][1] = win_v_q[i][2];
			sh_v[i][2] = ctl_s1.first ? 1'b0 : new_v[i];
			sh_d[i][0] = win_d_q[i][1];
			sh_d[i][1] = win_d_q[i][2];
			sh_d[i][2] = ctl_s1.first ? '0 : new_d[i];
		end
	end

	// The 3x3 window: shifts by one column, restarts at the first column of a row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win_v_q[i] <= 3'b000;
			end
		end else if (ram_we) begin
			for (int i = 0; i < 3; i++) begin
				if (ctl_s1.first) begin
					win_v_q[i] <= {new_v[i], 2'b00};
				end else begin
					win_v_q[i] <= sh_v[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			for (int i = 0; i < 3; i++) begin
				win_d_q[i][0] <= sh_d[i][0];
				win_d_q[i][1] <= sh_d[i][1];
				win_d_q[i][2] <= new_d[i];
			end
		end
	end

	// Stage two holds the shifted window; stage three the masked differences.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2.has_centre <= ctl_s1.has_centre;
			ctl_s2.last       <= ctl_s1.last;
			ctl_s2.restart    <= ctl_s1.restart;
			snap_v_s2         <= sh_v;
			snap_d_s2         <= sh_d;
			ctl_s3            <= ctl_s2;
			diff_s3           <= diff;
			ctl_s4            <= ctl_s3;
			code_s4           <= code_max;
		end
	end

	// Absolute difference of every existing neighbor to the centre; the centre
	// itself gives zero and so does not disturb the maximum.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (!snap_v_s2[1][1] || !snap_v_s2[i][j]) begin
					diff[i][j] = '0;
				end else if (snap_d_s2[i][j] > snap_d_s2[1][1]) begin
					diff[i][j] = snap_d_s2[i][j] - snap_d_s2[1][1];
				end else begin
					diff[i][j] = snap_d_s2[1][1] - snap_d_s2[i][j];
				end
			end
		end
	end

	// Stage three: largest difference is the pixel's edge code.
	always_comb begin
		code_max = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (diff_s3[i][j] > code_max) begin
					code_max = diff_s3[i][j];
				end
			end
		end
	end

	// Stage four: run-length encoder, closing a run on a code change and at the end.
	always_comb begin
		base_len  = ctl_s4.restart ? '0 : cur_len_q;
		base_code = ctl_s4.restart ? '0 : cur_code_q;
		push0     = 1'b0;
		mid_len   = base_len;
		mid_code  = base_code;
		if (ctl_s4.has_centre) begin
			if ((base_len != '0) && (code_s4 == base_code)) begin
				if (base_len != rlee_pkg::RUN_MAX) begin
					mid_len = base_len + rlee_pkg::RUN_W'(1);
				end
			end else begin
				push0    = (base_len != '0);
				mid_code = code_s4;
				mid_len  = rlee_pkg::RUN_W'(1);
			end
		end
		push1 = ctl_s4.last && (mid_len != '0);
		push0 = push0 & v_s4 & adv;
		push1 = push1 & v_s4 & adv;

		res0.code   = base_code;
		res0.length = base_len;
		res0.last   = 1'b0;
		res1.code   = mid_code;
		res1.length = mid_len;
		res1.last   = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_code_q <= '0;
			cur_len_q  <= '0;
		end else if (cfg_wr) begin
			cur_code_q <= '0;
			cur_len_q  <= '0;
		end else if (adv && v_s4) begin
			if (push1) begin
				cur_code_q <= '0;
				cur_len_q  <= '0;
			end else begin
				cur_code_q <= mid_code;
				cur_len_q  <= mid_len;
			end
		end
	end

	// Result queue: up to two pushes and one pop per cycle.
	assign pop  = run_valid & ~run_stall;
	assign head = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (push1) begin
			fifo_q[wr_ptr_q + rlee_pkg::FIFO_AW'(push0)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + rlee_pkg::FIFO_AW'(push0) + rlee_pkg::FIFO_AW'(push1);
			rd_ptr_q <= rd_ptr_q + rlee_pkg::FIFO_AW'(pop);
			count_q  <= count_q + (rlee_pkg::FIFO_AW + 1)'(push0)
				+ (rlee_pkg::FIFO_AW + 1)'(push1) - (rlee_pkg::FIFO_AW + 1)'(pop);
		end
	end

	assign run_valid  = (count_q != '0);
	assign edge_code  = head.code;
	assign run_length = head.length;
	assign last_run   = head.last;

endmodule

>>> rtl/core/rlee_checker.sv
`timescale 1ns / 1ps

module rlee_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       pixel_stall,
	input logic                       run_valid,
	input logic                       run_stall,
	input logic [7:0]                 edge_code,
	input logic [rlee_pkg::RUN_W-1:0] run_length,
	input logic                       last_run
);

	// A stalled run stays offered.
	a_run_hold: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && run_stall |=> run_valid)
		else $error("run_valid dropped while stalled");

	// A stalled run keeps its payload.
	a_run_stable: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid && run_stall |=> $stable({edge_code, run_length, last_run}))
		else $error("run payload changed while stalled");

	// Every run covers at least one pixel.
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		run_valid |-> (run_length != '0))
		else $error("run of zero length");

	// The pixel side stalls only when results are queued.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> run_valid)
		else $error("pixel_stall without queued runs");

endmodule

bind rle_edge_code_encoder rlee_checker u_rlee_checker (.*);
